@@ rtl/core/elc_pkg.sv @@
// ----------------------------------------------------------------------------
// elc_pkg
// Shared types, constants and helpers of the eddy loss coefficient evaluator.
// ----------------------------------------------------------------------------
package elc_pkg;

	// polynomial size and default number of used terms
	localparam int MAX_POW   = 6;
	localparam int TERMS_DEF = 6;

	// datapath widths
	localparam int ACC_W = 48;   // Horner accumulator, Q.24
	localparam int NUM_W = 62;   // rounded dividend magnitude
	localparam int DEN_W = 16;   // divisor magnitude
	localparam int CFG_IDX_W = 8;

	// result limits, Q24.24
	localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
	localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

	// function codes
	localparam logic [2:0] FN_VALUE = 3'd0;
	localparam logic [2:0] FN_DDT   = 3'd1;
	localparam logic [2:0] FN_DDB   = 3'd2;
	localparam logic [2:0] FN_D2B   = 3'd3;
	localparam logic [2:0] FN_DTDB  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_EQ  = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 8'd2;

	// reset value of the constant term pair: 1.0 at both temperatures
	localparam logic [63:0] COEF0_RST = 64'h0100_0000_0100_0000;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [15:0] temperature;
		logic [15:0]        flux_peak;
	} elc_in_t;

	typedef struct packed {
		logic signed [47:0] coefficient;
		logic [1:0]         status;
	} elc_out_t;

	// side information carried through the divider
	typedef struct packed {
		logic                    active;
		logic                    slope;
		logic                    deq;
		logic                    neg;
		logic signed [ACC_W-1:0] q0;
	} elc_dside_t;

	// flux derivative order of a function code
	function automatic logic [1:0] func_order(input logic [2:0] f);
		logic [1:0] o;
		o = 2'd0;
		if (f == FN_DDB || f == FN_DTDB) begin
			o = 2'd1;
		end else if (f == FN_D2B) begin
			o = 2'd2;
		end
		return o;
	endfunction

	// temperature slope modes
	function automatic logic func_slope(input logic [2:0] f);
		return (f == FN_DDT) || (f == FN_DTDB);
	endfunction

	// modes that produce a computed result; other codes yield zero
	function automatic logic func_active(input logic [2:0] f);
		return f <= FN_DTDB;
	endfunction

	// derivative weight of power i for a flux derivative order
	function automatic logic [4:0] weight(input logic [1:0] order, input int i);
		logic [4:0] w;
		w = 5'd1;
		if (order == 2'd1) begin
			w = 5'(i);
		end else if (order == 2'd2) begin
			w = 5'(i * (i - 1));
		end
		return w;
	endfunction

endpackage

@@ rtl/core/elc_horner.sv @@
// ----------------------------------------------------------------------------
// elc_horner
// Pipelined Horner evaluation of both temperature polynomials, two stages
// per power: multiply by flux, then round and add the weighted coefficient.
// ----------------------------------------------------------------------------
module elc_horner #(
	parameter int TERMS = elc_pkg::TERMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  elc_pkg::elc_in_t                    in_item,
	input  logic [TERMS-1:0][63:0]              coef,
	output logic                                out_valid,
	output elc_pkg::elc_in_t                    out_item,
	output logic signed [elc_pkg::ACC_W-1:0]    q0,
	output logic signed [elc_pkg::ACC_W-1:0]    q1
);

	localparam int P = elc_pkg::MAX_POW;
	localparam int AW = elc_pkg::ACC_W;

	// step boundaries
	logic                 vld_s  [0:P];
	elc_pkg::elc_in_t     item_s [0:P];
	logic signed [AW-1:0] acc0_s [0:P];
	logic signed [AW-1:0] acc1_s [0:P];

	assign vld_s[0]  = in_valid;
	assign item_s[0] = in_item;
	assign acc0_s[0] = '0;
	assign acc1_s[0] = '0;

	for (genvar j = 0; j < P; j++) begin : g_step
		localparam int PW = P - 1 - j;

		logic signed [31:0]   c0;
		logic signed [31:0]   c1;
		logic [1:0]           ord;
		logic signed [64:0]   p0;
		logic signed [64:0]   p1;
		logic signed [37:0]   w0;
		logic signed [37:0]   w1;
		logic signed [63:0]   r0;
		logic signed [63:0]   r1;

		// multiply stage registers
		logic                 vld_m_s;
		elc_pkg::elc_in_t     item_m_s;
		logic signed [63:0]   prod0_m_s;
		logic signed [63:0]   prod1_m_s;
		logic signed [37:0]   wc0_m_s;
		logic signed [37:0]   wc1_m_s;
		logic signed [AW-1:0] keep0_m_s;
		logic signed [AW-1:0] keep1_m_s;

		// powers beyond the used terms contribute nothing
		if (PW < TERMS) begin : g_used
			assign c0 = $signed(coef[PW][31:0]);
			assign c1 = $signed(coef[PW][63:32]);
		end else begin : g_unused
			assign c0 = '0;
			assign c1 = '0;
		end

		// flux product and weighted coefficient
		always_comb begin
			ord = elc_pkg::func_order(item_s[j].func);
			p0  = acc0_s[j] * $signed({1'b0, item_s[j].flux_peak});
			p1  = acc1_s[j] * $signed({1'b0, item_s[j].flux_peak});
			w0  = $signed({1'b0, elc_pkg::weight(ord, PW)}) * c0;
			w1  = $signed({1'b0, elc_pkg::weight(ord, PW)}) * c1;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_m_s <= 1'b0;
			end else begin
				vld_m_s <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			item_m_s  <= item_s[j];
			prod0_m_s <= p0[63:0];
			prod1_m_s <= p1[63:0];
			wc0_m_s   <= w0;
			wc1_m_s   <= w1;
			keep0_m_s <= acc0_s[j];
			keep1_m_s <= acc1_s[j];
		end

		// round to nearest, ties up, then add; powers below the order are skipped
		always_comb begin
			r0 = prod0_m_s + 64'sd8192;
			r1 = prod1_m_s + 64'sd8192;
		end

		logic                 vld_a_s;
		elc_pkg::elc_in_t     item_a_s;
		logic signed [AW-1:0] acc0_a_s;
		logic signed [AW-1:0] acc1_a_s;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a_s <= 1'b0;
			end else begin
				vld_a_s <= vld_m_s;
			end
		end

		always_ff @(posedge clk) begin
			item_a_s <= item_m_s;
			if (PW < int'(elc_pkg::func_order(item_m_s.func))) begin
				acc0_a_s <= keep0_m_s;
				acc1_a_s <= keep1_m_s;
			end else begin
				acc0_a_s <= $signed(r0[AW+13:14]) + AW'(wc0_m_s);
				acc1_a_s <= $signed(r1[AW+13:14]) + AW'(wc1_m_s);
			end
		end

		assign vld_s[j+1]  = vld_a_s;
		assign item_s[j+1] = item_a_s;
		assign acc0_s[j+1] = acc0_a_s;
		assign acc1_s[j+1] = acc1_a_s;
	end

	assign out_valid = vld_s[P];
	assign out_item  = item_s[P];
	assign q0        = acc0_s[P];
	assign q1        = acc1_s[P];

endmodule

@@ rtl/core/elc_div.sv @@
// ----------------------------------------------------------------------------
// elc_div
// Pipelined restoring divider, one quotient bit per stage, with a side
// information word carried alongside each operand.
// ----------------------------------------------------------------------------
module elc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [elc_pkg::NUM_W-1:0]     num,
	input  logic [elc_pkg::DEN_W-1:0]     den,
	input  elc_pkg::elc_dside_t           in_side,
	output logic                          out_valid,
	output logic [elc_pkg::NUM_W-1:0]     quot,
	output elc_pkg::elc_dside_t           out_side
);

	localparam int NW = elc_pkg::NUM_W;
	localparam int DW = elc_pkg::DEN_W;

	logic                vld_s  [0:NW];
	logic [DW-1:0]       rem_s  [0:NW];
	logic [NW-1:0]       nq_s   [0:NW];
	elc_pkg::elc_dside_t side_s [0:NW];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign nq_s[0]   = num;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < NW; k++) begin : g_bit
		logic [DW:0]         trial;
		logic                ge;
		logic [DW:0]         diff;
		logic                vld_k_s;
		logic [DW-1:0]       rem_k_s;
		logic [NW-1:0]       nq_k_s;
		elc_pkg::elc_dside_t side_k_s;

		// shift in the next dividend bit and try a subtract
		always_comb begin
			trial = {rem_s[k], nq_s[k][NW-1]};
			ge    = trial >= {1'b0, den};
			diff  = trial - {1'b0, den};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_k_s <= 1'b0;
			end else begin
				vld_k_s <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_k_s  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nq_k_s   <= {nq_s[k][NW-2:0], ge};
			side_k_s <= side_s[k];
		end

		assign vld_s[k+1]  = vld_k_s;
		assign rem_s[k+1]  = rem_k_s;
		assign nq_s[k+1]   = nq_k_s;
		assign side_s[k+1] = side_k_s;
	end

	assign out_valid = vld_s[NW];
	assign quot      = nq_s[NW];
	assign out_side  = side_s[NW];

endmodule

@@ rtl/core/eddy_loss_coefficient_eval_unit.sv @@
// ----------------------------------------------------------------------------
// eddy_loss_coefficient_eval_unit
// Temperature-interpolated eddy loss coefficient and its derivatives.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and pulse start; a transfer happens at each
//   clock edge with start high and busy low. busy is never raised, so one
//   command can be issued every cycle.
//   Result channel: done is high for one cycle with result valid; results
//   leave in command order. Pipeline: one input stage, twelve Horner
//   stages (multiply, then round and add, for each of six powers), three
//   stages of interpolation set-up, 62 divider stages (one quotient bit
//   each), a sign stage and the output register. Throughput is one item
//   per cycle. Configuration: cfg_ready is always high; a cfg transfer
//   changes the register that cfg_index names, if any. The user must make
//   writes while no command is in flight; the block does not enforce it.
//   Reset clears the pipeline valid bits and loads the default registers:
//   both fit temperatures 0.0 and 1.0, constant term 1.0, other terms 0.
//   The receiver cannot stall, so nothing is held back at the output.
// ----------------------------------------------------------------------------
module eddy_loss_coefficient_eval_unit #(
	parameter int TERMS = elc_pkg::TERMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  elc_pkg::elc_in_t                  cmd,
	output logic                              done,
	output elc_pkg::elc_out_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [elc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [63:0]                       cfg_data
);

	localparam int AW  = elc_pkg::ACC_W;
	localparam int LAT = 4 + 2 * elc_pkg::MAX_POW + elc_pkg::NUM_W + 2;

	// configuration registers
	logic signed [15:0]     temp_low_q;
	logic signed [15:0]     temp_high_q;
	logic [TERMS-1:0][63:0] coef_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_low_q  <= '0;
			temp_high_q <= 16'sd64;
			for (int k = 0; k < TERMS; k++) begin
				coef_q[k] <= (k == 0) ? elc_pkg::COEF0_RST : 64'd0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == elc_pkg::CFG_TEMP_LOW) begin
				temp_low_q <= cfg_data[15:0];
			end
			if (cfg_index == elc_pkg::CFG_TEMP_HIGH) begin
				temp_high_q <= cfg_data[15:0];
			end
			for (int k = 0; k < TERMS; k++) begin
				if (cfg_index == elc_pkg::CFG_COEF_BASE + elc_pkg::CFG_IDX_W'(k)) begin
					coef_q[k] <= cfg_data;
				end
			end
		end
	end

	// temperature span and its magnitude
	logic signed [16:0]            dspan;
	logic [16:0]                   dneg;
	logic [elc_pkg::DEN_W-1:0]     dabs;

	always_comb begin
		dspan = 17'(temp_high_q) - 17'(temp_low_q);
		dneg  = 17'(-dspan);
		dabs  = dspan[16] ? dneg[15:0] : dspan[15:0];
	end

	// command transfer
	logic             vld_s1;
	elc_pkg::elc_in_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= cmd;
	end

	// flux polynomials at both fit temperatures
	logic                 hv;
	elc_pkg::elc_in_t     hitem;
	logic signed [AW-1:0] hq0;
	logic signed [AW-1:0] hq1;

	elc_horner #(
		.TERMS (TERMS)
	) u_horner (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_item   (item_s1),
		.coef      (coef_q),
		.out_valid (hv),
		.out_item  (hitem),
		.q0        (hq0),
		.q1        (hq1)
	);

	// polynomial difference and temperature offset
	logic                 vld_s2;
	logic signed [AW:0]   diff_s2;
	logic signed [16:0]   tt_s2;
	logic signed [AW-1:0] q0_s2;
	logic                 slope_s2;
	logic                 active_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= hv;
		end
	end

	always_ff @(posedge clk) begin
		diff_s2   <= (AW+1)'(hq1) - (AW+1)'(hq0);
		tt_s2     <= 17'(hitem.temperature) - 17'(temp_low_q);
		q0_s2     <= hq0;
		slope_s2  <= elc_pkg::func_slope(hitem.func);
		active_s2 <= elc_pkg::func_active(hitem.func);
	end

	// interpolation numerator
	logic signed [65:0] mprod;
	logic               vld_s3;
	logic signed [63:0] num_s3;
	logic signed [AW-1:0] q0_s3;
	logic               slope_s3;
	logic               active_s3;

	assign mprod = tt_s2 * diff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		num_s3    <= slope_s2 ? (64'(diff_s2) <<< 6) : mprod[63:0];
		q0_s3     <= q0_s2;
		slope_s3  <= slope_s2;
		active_s3 <= active_s2;
	end

	// magnitude plus half divisor for round-half-away division
	logic [63:0]                  nabs;
	logic                         vld_s4;
	logic [elc_pkg::NUM_W-1:0]    num_s4;
	elc_pkg::elc_dside_t          side_s4;

	assign nabs = num_s3[63] ? 64'(-num_s3) : 64'(num_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		num_s4         <= nabs[elc_pkg::NUM_W-1:0] + elc_pkg::NUM_W'(dabs >> 1);
		side_s4.active <= active_s3;
		side_s4.slope  <= slope_s3;
		side_s4.deq    <= (dspan == 17'sd0);
		side_s4.neg    <= num_s3[63] ^ dspan[16];
		side_s4.q0     <= q0_s3;
	end

	// division by the temperature span
	logic                      dv;
	logic [elc_pkg::NUM_W-1:0] dquot;
	elc_pkg::elc_dside_t       dside;

	elc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.num       (num_s4),
		.den       (dabs),
		.in_side   (side_s4),
		.out_valid (dv),
		.quot      (dquot),
		.out_side  (dside)
	);

	// apply the quotient sign
	logic signed [elc_pkg::NUM_W:0] qpos;
	logic                           vld_s5;
	logic signed [elc_pkg::NUM_W:0] qs_s5;
	elc_pkg::elc_dside_t            side_s5;

	assign qpos = $signed({1'b0, dquot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		qs_s5   <= dside.neg ? -qpos : qpos;
		side_s5 <= dside;
	end

	// final sum, special cases and saturation
	logic signed [63:0] rsum;
	elc_pkg::elc_out_t  res_d;

	always_comb begin
		rsum = side_s5.slope ? 64'(qs_s5) : 64'(side_s5.q0) + 64'(qs_s5);
		res_d.coefficient = '0;
		res_d.status      = elc_pkg::ST_OK;
		priority if (!side_s5.active) begin
			res_d.coefficient = '0;
		end else if (side_s5.deq) begin
			res_d.status      = elc_pkg::ST_EQ;
			res_d.coefficient = side_s5.slope ? '0 : side_s5.q0;
		end else if (rsum > elc_pkg::OUT_MAX) begin
			res_d.status      = elc_pkg::ST_SAT;
			res_d.coefficient = elc_pkg::OUT_MAX[47:0];
		end else if (rsum < elc_pkg::OUT_MIN) begin
			res_d.status      = elc_pkg::ST_SAT;
			res_d.coefficient = elc_pkg::OUT_MIN[47:0];
		end else begin
			res_d.coefficient = rsum[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		result <= res_d;
	end

	// every command transfer is followed by done after the pipeline latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after command transfer");

	// a saturated result sits on one of the two limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == elc_pkg::ST_SAT) |->
		(result.coefficient == elc_pkg::OUT_MAX[47:0] ||
		 result.coefficient == elc_pkg::OUT_MIN[47:0]))
		else $error("saturation flagged off the limits");

	// status code three is never produced
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status != 2'd3))
		else $error("undefined status code");

endmodule
